### rtl/core/dod_pkg.sv
package dod_pkg;

	// Widths of the data paths.
	localparam int ValueWidth = 64;
	localparam int CodeWidth  = 36;
	localparam int LenWidth   = 6;
	localparam int PendWidth  = 7;
	localparam int CntWidth   = 3;
	localparam int AccWidth   = PendWidth + CodeWidth;
	localparam int NbWidth    = 4;

	// Depth of the queue between the front and back parts.
	localparam int QDepth     = 4;
	localparam int QPtrWidth  = $clog2(QDepth);
	localparam int QCntWidth  = $clog2(QDepth + 1);

	// Biases of the short code classes.
	localparam logic [ValueWidth-1:0] Bias7  = 64'd63;
	localparam logic [ValueWidth-1:0] Bias9  = 64'd255;
	localparam logic [ValueWidth-1:0] Bias12 = 64'd2047;
	localparam logic [ValueWidth-1:0] Bias32 = 64'h0000_0000_8000_0000;

	// Upper limits of the biased values.
	localparam logic [ValueWidth-1:0] Lim7   = 64'd127;
	localparam logic [ValueWidth-1:0] Lim9   = 64'd511;
	localparam logic [ValueWidth-1:0] Lim12  = 64'd4095;
	localparam logic [ValueWidth-1:0] Lim32  = 64'h0000_0000_FFFF_FFFF;

	// Class prefixes, sent first.
	localparam logic [1:0] Prefix7  = 2'h2;
	localparam logic [2:0] Prefix9  = 3'h6;
	localparam logic [3:0] Prefix12 = 4'hE;
	localparam logic [3:0] Prefix32 = 4'hF;

	// Code word lengths.
	localparam logic [LenWidth-1:0] Len0  = 6'd1;
	localparam logic [LenWidth-1:0] Len7  = 6'd9;
	localparam logic [LenWidth-1:0] Len9  = 6'd12;
	localparam logic [LenWidth-1:0] Len12 = 6'd16;
	localparam logic [LenWidth-1:0] Len32 = 6'd36;

	localparam logic [NbWidth-1:0] RawBytes = 4'd8;

	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_STREAM
	} pos_t;

	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_VARINT,
		KIND_BITS,
		KIND_ERROR
	} kind_t;

	// One unit of work for the back part.
	typedef struct packed {
		kind_t                  kind;
		logic                   last;
		logic [NbWidth-1:0]     nbytes;
		logic [ValueWidth-1:0]  data;
	} dod_entry_t;

	function automatic logic [ValueWidth-1:0] zigzag(input logic [ValueWidth-1:0] x);
		zigzag = {x[ValueWidth-2:0], 1'b0} ^ {ValueWidth{x[ValueWidth-1]}};
	endfunction

endpackage

### rtl/core/dod_front.sv
module dod_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [dod_pkg::ValueWidth-1:0] sample_value,
	input  logic                           last_in,
	output logic                           q_push,
	output dod_pkg::dod_entry_t            q_entry,
	input  logic                           q_full
);
	import dod_pkg::*;

	logic                  adv;

	// Stage 1: delta.
	logic                  v_s1;
	logic                  last_s1;
	pos_t                  pos_s1;
	logic [ValueWidth-1:0] value_s1;
	logic [ValueWidth-1:0] delta_s1;
	logic [ValueWidth-1:0] prev_value_q;
	pos_t                  pos_q;

	// Stage 2: delta-of-delta or the word to send.
	logic                  v_s2;
	logic                  last_s2;
	pos_t                  pos_s2;
	logic [ValueWidth-1:0] word_s2;
	logic [ValueWidth-1:0] delta_hist_q;

	// Stage 3: classified item.
	logic                  v_s3;
	logic                  last_s3;
	kind_t                 kind_s3;
	logic [ValueWidth-1:0] data_s3;
	logic [LenWidth-1:0]   len_s3;

	// Bit packing state.
	logic [PendWidth-1:0]  pend_bits_q;
	logic [CntWidth-1:0]   pend_cnt_q;
	logic                  failed_q;

	logic [ValueWidth-1:0] b7, b9, b12, b32, zz;
	kind_t                 kind_c;
	logic [ValueWidth-1:0] data_c;
	logic [LenWidth-1:0]   len_c;

	logic [AccWidth-1:0]   acc;
	logic [LenWidth-1:0]   total;
	logic [ValueWidth-1:0] aligned;
	logic                  pad;
	logic [NbWidth-1:0]    bit_bytes;
	logic [PendWidth-1:0]  pend_mask;
	logic                  want_push;

	assign adv  = !(want_push && q_full);
	assign full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			pos_q <= POS_FIRST;
		end else if (adv) begin
			v_s1 <= push;
			if (push) begin
				if (last_in) begin
					pos_q <= POS_FIRST;
				end else if (pos_q == POS_FIRST) begin
					pos_q <= POS_SECOND;
				end else begin
					pos_q <= POS_STREAM;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			value_s1     <= sample_value;
			delta_s1     <= sample_value - prev_value_q;
			pos_s1       <= pos_q;
			last_s1      <= last_in;
			prev_value_q <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			delta_hist_q <= '0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1 && pos_s1 != POS_FIRST) begin
				delta_hist_q <= delta_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			last_s2 <= last_s1;
			pos_s2  <= pos_s1;
			unique case (pos_s1)
				POS_FIRST:  word_s2 <= value_s1;
				POS_SECOND: word_s2 <= delta_s1;
				default:    word_s2 <= delta_s1 - delta_hist_q;
			endcase
		end
	end

	// Classification of the stage 2 word.
	always_comb begin
		b7  = word_s2 + Bias7;
		b9  = word_s2 + Bias9;
		b12 = word_s2 + Bias12;
		b32 = word_s2 + Bias32;
		zz  = zigzag(word_s2);
		kind_c = KIND_BITS;
		data_c = '0;
		len_c  = Len0;
		unique case (pos_s2)
			POS_FIRST: begin
				kind_c = KIND_RAW;
				data_c = word_s2;
			end
			POS_SECOND: begin
				kind_c = KIND_VARINT;
				data_c = zz;
			end
			default: begin
				if (word_s2 == '0) begin
					len_c = Len0;
				end else if (b7 <= Lim7) begin
					data_c = {55'd0, Prefix7, b7[6:0]};
					len_c  = Len7;
				end else if (b9 <= Lim9) begin
					data_c = {52'd0, Prefix9, b9[8:0]};
					len_c  = Len9;
				end else if (b12 <= Lim12) begin
					data_c = {48'd0, Prefix12, b12[11:0]};
					len_c  = Len12;
				end else if (b32 <= Lim32) begin
					data_c = {28'd0, Prefix32, zz[31:0]};
					len_c  = Len32;
				end else begin
					kind_c = KIND_ERROR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			last_s3 <= last_s2;
			kind_s3 <= kind_c;
			data_s3 <= data_c;
			len_s3  <= len_c;
		end
	end

	// Packing of a code word behind the pending bits, aligned to the top.
	always_comb begin
		acc       = ({{CodeWidth{1'b0}}, pend_bits_q} << len_s3)
			| {{PendWidth{1'b0}}, data_s3[CodeWidth-1:0]};
		total     = {3'd0, pend_cnt_q} + len_s3;
		aligned   = {{(ValueWidth-AccWidth){1'b0}}, acc} << (7'd64 - {1'b0, total});
		pad       = last_s3 && (total[2:0] != 3'd0);
		bit_bytes = {1'b0, total[5:3]} + {3'd0, pad};
		pend_mask = ~(7'h7F << total[2:0]);

		q_entry.kind   = kind_s3;
		q_entry.last   = last_s3;
		q_entry.nbytes = RawBytes;
		q_entry.data   = data_s3;
		want_push      = v_s3 && !failed_q;
		case (kind_s3)
			KIND_BITS: begin
				q_entry.nbytes = bit_bytes;
				q_entry.data   = aligned;
				want_push      = v_s3 && !failed_q && (bit_bytes != '0);
			end
			KIND_ERROR: begin
				q_entry.nbytes = 4'd1;
				q_entry.data   = '0;
				q_entry.last   = 1'b1;
			end
			default: ;
		endcase
	end

	assign q_push = want_push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			failed_q    <= 1'b0;
		end else if (adv && v_s3) begin
			if (failed_q) begin
				if (last_s3) begin
					failed_q <= 1'b0;
				end
			end else if (last_s3) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else if (kind_s3 == KIND_ERROR) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				failed_q    <= 1'b1;
			end else if (kind_s3 == KIND_BITS) begin
				pend_bits_q <= acc[PendWidth-1:0] & pend_mask;
				pend_cnt_q  <= total[2:0];
			end
		end
	end

endmodule

### rtl/core/dod_queue.sv
module dod_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  dod_pkg::dod_entry_t wr_entry,
	output logic                q_full,
	input  logic                rd_en,
	output dod_pkg::dod_entry_t rd_entry,
	output logic                q_empty
);
	import dod_pkg::*;

	dod_entry_t             slots_q [QDepth];
	logic [QPtrWidth-1:0]   wr_ptr_q;
	logic [QPtrWidth-1:0]   rd_ptr_q;
	logic [QCntWidth-1:0]   count_q;

	assign q_full   = (count_q == QCntWidth'(QDepth));
	assign q_empty  = (count_q == '0);
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/dod_back.sv
module dod_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dod_pkg::dod_entry_t q_entry,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          out_byte,
	output logic                last_out,
	output logic                error_flag
);
	import dod_pkg::*;

	logic                  work_v_q;
	kind_t                 work_kind_q;
	logic                  work_last_q;
	logic [NbWidth-1:0]    work_rem_q;
	logic [ValueWidth-1:0] work_data_q;

	logic                  out_v_q;

	logic                  step;
	logic                  load;
	logic                  final_byte;
	logic [7:0]            byte_c;
	logic                  err_c;
	logic [ValueWidth-1:0] next_data;
	logic [ValueWidth-1:0] vrest;

	assign step  = work_v_q && (!out_v_q || pop);
	assign load  = !work_v_q || (step && final_byte);
	assign q_pop = load && !q_empty;
	assign empty = !out_v_q;

	// Next byte of the current entry.
	always_comb begin
		vrest      = work_data_q >> 7;
		byte_c     = work_data_q[7:0];
		err_c      = 1'b0;
		final_byte = (work_rem_q == 4'd1);
		next_data  = work_data_q >> 8;
		unique case (work_kind_q)
			KIND_RAW: ;
			KIND_VARINT: begin
				byte_c     = {vrest != '0, work_data_q[6:0]};
				final_byte = (vrest == '0);
				next_data  = vrest;
			end
			KIND_BITS: begin
				byte_c    = work_data_q[ValueWidth-1 -: 8];
				next_data = work_data_q << 8;
			end
			default: begin
				byte_c     = '0;
				err_c      = 1'b1;
				final_byte = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load) begin
				work_v_q <= !q_empty;
			end
			if (step) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_kind_q <= q_entry.kind;
			work_last_q <= q_entry.last;
			work_rem_q  <= q_entry.nbytes;
			work_data_q <= q_entry.data;
		end else if (step) begin
			work_rem_q  <= work_rem_q - 1'b1;
			work_data_q <= next_data;
		end
		if (step) begin
			out_byte   <= byte_c;
			last_out   <= final_byte && work_last_q;
			error_flag <= err_c;
		end
	end

endmodule

### rtl/core/delta_of_delta_encoder_core.sv
// Delta-of-delta encoder. Each pushed item is one signed 64-bit value, and
// last_in marks the final value of a sequence. The encoding comes out one byte
// per popped item: the first value as 8 bytes, least significant first; then
// the first delta as a zigzag LEB128 varint of 1 to 10 bytes; then, for every
// later value, a prefix code of the delta-of-delta (1, 9, 12, 16 or 36 bits)
// packed MSB-first into bytes, with the final partial byte zero padded when
// the sequence ends. last_out marks the final byte of a sequence. A
// delta-of-delta outside the signed 32-bit range yields a single item with
// out_byte 0, last_out 1 and error_flag 1; the rest of that sequence, up to
// and including its last value, yields nothing. A value that completes no
// byte yields no item. The front part takes one value per cycle while full
// is low, through a three-stage pipeline (delta, delta-of-delta,
// classification and packing) and hands work to a four-entry queue; the back
// part sends exactly one byte per cycle while pop keeps up and the queue holds
// work. A value makes 8 bytes if it is the first, 1 to 10 if it is the second
// and 0 to 6 if it is a stream value (at most 5 in steady state). full rises
// when the queue is full and the front pipeline holds a value that needs a
// queue slot.
module delta_of_delta_encoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [dod_pkg::ValueWidth-1:0] sample_value,
	input  logic                           last_in,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           last_out,
	output logic                           error_flag
);
	import dod_pkg::*;

	dod_entry_t wr_entry;
	dod_entry_t rd_entry;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;

	// Front part: computes deltas, classifies and packs each value.
	dod_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.last_in      (last_in),
		.q_push       (q_push),
		.q_entry      (wr_entry),
		.q_full       (q_full)
	);

	// Queue of work entries between the two parts.
	dod_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.q_empty  (q_empty)
	);

	// Back part: turns each entry into bytes, one per cycle while pop keeps up.
	dod_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_entry    (rd_entry),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_out   (last_out),
		.error_flag (error_flag)
	);

endmodule

### sim/tb_delta_of_delta_encoder_core.sv
module tb_delta_of_delta_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dod_pkg::*;

	// The run is cut off here if the block stops making progress.
	localparam int CycleLimit = 200000;
	// Cycles allowed after the last expected byte, so that an item which makes
	// no byte can still leave the pipeline and the queue.
	localparam int TailCycles = 24;
	// Chance in a hundred that a side idles in a given cycle.
	localparam int IdlePercent = 22;
	localparam int RandomItems = 360;

	// One byte of the encoded stream as it should appear on the result ports.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] sample_value = '0;
	logic        last_in = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        last_out;
	logic        error_flag;

	delta_of_delta_encoder_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_value(sample_value),
		.last_in     (last_in),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_out    (last_out),
		.error_flag  (error_flag)
	);

	always #5 clk = ~clk;

	// Bytes the encoder still owes, oldest first.
	enc_byte_t expected_bytes[$];
	int        mismatch_count = 0;
	int        items_sent = 0;
	int        cycle_count = 0;
	// While set, neither side idles.
	bit        steady = 1'b0;

	// Our own copy of the encoder state.
	logic [63:0] prev_value;
	logic [63:0] delta_hist;
	pos_t        seq_pos;
	logic [6:0]  pend_bits;
	logic [2:0]  pend_count;
	bit          seq_failed;

	// Stimulus state: the sequence being generated, so that a chosen
	// delta-of-delta can be turned into the next value.
	logic [63:0] gen_value;
	logic [63:0] gen_delta;

	function automatic void clear_encoder_state();
		prev_value = '0;
		delta_hist = '0;
		seq_pos    = POS_FIRST;
		pend_bits  = '0;
		pend_count = '0;
		seq_failed = 1'b0;
	endfunction

	function automatic void owe_byte(input logic [7:0] data, input logic last, input logic err);
		enc_byte_t b;
		b.data = data;
		b.last = last;
		b.err  = err;
		expected_bytes.push_back(b);
	endfunction

	// Appends a code word to the bit stream and owes every byte that it
	// completes, most significant bit first.
	function automatic void pack_code(input logic [63:0] code, input int len);
		logic [63:0] acc;
		int          total;
		acc   = (64'(pend_bits) << len) | code;
		total = int'(pend_count) + len;
		while (total >= 8) begin
			owe_byte(8'(acc >> (total - 8)), 1'b0, 1'b0);
			total -= 8;
		end
		pend_count = 3'(total);
		pend_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
	endfunction

	// Works out the bytes that one accepted value causes and queues them.
	function automatic void encode_sample(input logic [63:0] v, input logic last);
		int          first_new;
		logic [63:0] delta;
		logic [63:0] dod;
		logic [63:0] zz;
		logic [15:0] padded;
		enc_byte_t   tail;
		first_new = expected_bytes.size();
		// After an out-of-range delta-of-delta the rest of the sequence is
		// swallowed, up to and including its final value.
		if (seq_failed) begin
			if (last)
				clear_encoder_state();
			return;
		end
		case (seq_pos)
			POS_FIRST: begin
				for (int i = 0; i < 8; i++)
					owe_byte(v[8*i +: 8], 1'b0, 1'b0);
				prev_value = v;
				seq_pos    = POS_SECOND;
			end
			POS_SECOND: begin
				// The first delta goes out as a zigzag LEB128 varint.
				delta = v - prev_value;
				zz    = {delta[62:0], 1'b0} ^ {64{delta[63]}};
				do begin
					owe_byte({zz[63:7] != '0, zz[6:0]}, 1'b0, 1'b0);
					zz = zz >> 7;
				end while (zz != '0);
				delta_hist = delta;
				prev_value = v;
				seq_pos    = POS_STREAM;
			end
			default: begin
				delta      = v - prev_value;
				dod        = delta - delta_hist;
				delta_hist = delta;
				prev_value = v;
				if (dod == '0) begin
					pack_code('0, 1);
				end else if (dod + Bias7 <= Lim7) begin
					pack_code((64'(Prefix7) << 7) | (dod + Bias7), 9);
				end else if (dod + Bias9 <= Lim9) begin
					pack_code((64'(Prefix9) << 9) | (dod + Bias9), 12);
				end else if (dod + Bias12 <= Lim12) begin
					pack_code((64'(Prefix12) << 12) | (dod + Bias12), 16);
				end else if (dod + Bias32 <= Lim32) begin
					zz = ({dod[62:0], 1'b0} ^ {64{dod[63]}}) & Lim32;
					pack_code((64'(Prefix32) << 32) | zz, 36);
				end else begin
					// Out of the signed 32-bit range: one error byte, and the
					// pending stream bits are thrown away.
					owe_byte(8'h00, 1'b1, 1'b1);
					if (last) begin
						clear_encoder_state();
					end else begin
						pend_bits  = '0;
						pend_count = '0;
						seq_failed = 1'b1;
					end
					return;
				end
				// The final value flushes a partial byte, zero padded at
				// its low end.
				if (last && pend_count != '0) begin
					padded = 16'(pend_bits) << (8 - int'(pend_count));
					owe_byte(padded[7:0], 1'b0, 1'b0);
				end
			end
		endcase
		if (last) begin
			if (expected_bytes.size() > first_new) begin
				tail      = expected_bytes.pop_back();
				tail.last = 1'b1;
				expected_bytes.push_back(tail);
			end
			clear_encoder_state();
		end
	endfunction

	// Presents one value and waits for the block to take it. push is left
	// high afterwards so that the next item can follow in the very next
	// cycle; anything that waits for something else calls drain_results,
	// which lowers it first.
	task automatic send_sample(input logic [63:0] v, input logic last);
		if (!steady && $urandom_range(99) < IdlePercent) begin
			do begin
				push <= 1'b0;
				@(posedge clk);
			end while ($urandom_range(99) < IdlePercent);
		end
		push         <= 1'b1;
		sample_value <= v;
		last_in      <= last;
		do @(posedge clk); while (full);
		encode_sample(v, last);
		items_sent++;
	endtask

	task automatic send_first(input logic [63:0] v, input logic last);
		gen_value = v;
		gen_delta = '0;
		send_sample(v, last);
	endtask

	task automatic send_next(input logic [63:0] delta, input logic last);
		gen_delta = delta;
		gen_value = gen_value + delta;
		send_sample(gen_value, last);
	endtask

	task automatic send_with_dod(input logic [63:0] dod, input logic last);
		send_next(gen_delta + dod, last);
	endtask

	// Holds the sender off until every owed byte has come out, then lets the
	// pipeline settle in case the last items made no byte.
	task automatic drain_results();
		push <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// Sequences of a single value: eight raw bytes and nothing else.
	task automatic test_single_value_sequences();
		send_first(64'h8000_0000_0000_0000, 1'b1);
		send_first(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		drain_results();
	endtask

	// Two-value sequences end right after the varint. The first wraps to a
	// delta of -1 (one byte); the second gives the longest varint.
	task automatic test_first_delta_varint();
		send_first(64'h8000_0000_0000_0000, 1'b0);
		send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_first(64'h0, 1'b0);
		send_sample(64'h8000_0000_0000_0000, 1'b1);
		drain_results();
	endtask

	// One sequence that walks through every code class and edges of their ranges. The
	// leading zero delta-of-delta is one bit and makes no byte by itself.
	task automatic test_dod_code_classes();
		longint dods[10] = '{0, 64, -63, 65, 256, -255, 2048, 2049,
			64'sd2147483647, -64'sd2147483648};
		send_first(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_next(64'h0, 1'b0);
		foreach (dods[i])
			send_with_dod(dods[i], i == 9);
		drain_results();
	endtask

	// Delta-of-delta just past the 32-bit range on either side: once in the
	// middle of a sequence, whose tail must then be silent, and once on the
	// final value.
	task automatic test_out_of_range_dod();
		send_first(64'h0, 1'b0);
		send_next(64'h0, 1'b0);
		send_with_dod(64'sd2147483648, 1'b0);
		send_with_dod(64'h0, 1'b0);
		send_with_dod(64'd5, 1'b1);
		send_first(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_next(64'd3, 1'b0);
		send_with_dod(-64'sd2147483649, 1'b1);
		drain_results();
	endtask

	function automatic logic [63:0] random_dod();
		logic [63:0] d;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			d = '0;
		end else if (pick < 35) begin
			d = longint'($urandom_range(127)) - 63;
		end else if (pick < 55) begin
			d = longint'($urandom_range(511)) - 255;
		end else if (pick < 70) begin
			d = longint'($urandom_range(4095)) - 2047;
		end else if (pick < 97) begin
			d = longint'(int'($urandom));
		end else if (pick < 99) begin
			// Anywhere beyond 32 bits: breaking the sign run above bit 31
			// guarantees that.
			d = {$urandom, $urandom};
			if (d + Bias32 <= Lim32)
				d[40] = ~d[63];
		end else begin
			d = ($urandom_range(1) == 1) ? 64'sd2147483648 : -64'sd2147483649;
		end
		return d;
	endfunction

	// Mostly well-formed sequences of random length with random content.
	// The first stretch runs with no idling on either side; every so often
	// the sender waits until all owed bytes have arrived.
	task automatic test_random_sequences();
		int          start_count;
		int          next_drain;
		int          seq_len;
		int          pick;
		logic [63:0] delta;
		start_count = items_sent;
		next_drain  = start_count + 60;
		steady      = 1'b1;
		while (items_sent - start_count < RandomItems) begin
			if (items_sent - start_count >= 90)
				steady = 1'b0;
			pick = $urandom_range(99);
			if (pick < 8)
				seq_len = 1;
			else if (pick < 16)
				seq_len = 2;
			else
				seq_len = $urandom_range(14, 3);
			send_first({$urandom, $urandom}, seq_len == 1);
			if (seq_len > 1) begin
				pick = $urandom_range(99);
				if (pick < 50)
					delta = longint'($urandom_range(400)) - 200;
				else if (pick < 80)
					delta = longint'(int'($urandom));
				else
					delta = {$urandom, $urandom};
				send_next(delta, seq_len == 2);
			end
			for (int i = 2; i < seq_len; i++)
				send_with_dod(random_dod(), i == seq_len - 1);
			if (items_sent >= next_drain) begin
				drain_results();
				next_drain = items_sent + 60;
			end
		end
		steady = 1'b0;
		drain_results();
	endtask

	// Result side: every popped byte is checked against the oldest owed one,
	// and pop is redrawn for the next cycle.
	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected byte %02h last %b err %b", $realtime,
						out_byte, last_out, error_flag);
				mismatch_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data || last_out !== want.last ||
						error_flag !== want.err) begin
					if (mismatch_count < 10)
						$display("%0t: byte %02h last %b err %b, expected %02h %b %b",
							$realtime, out_byte, last_out, error_flag,
							want.data, want.last, want.err);
					mismatch_count++;
				end
			end
		end
		pop <= steady || ($urandom_range(99) >= IdlePercent);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clear_encoder_state();
		gen_value = '0;
		gen_delta = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_value_sequences();
		test_first_delta_varint();
		test_dod_code_classes();
		test_out_of_range_dod();
		test_random_sequences();
		// Anything still owed here is a byte that never came.
		mismatch_count += expected_bytes.size();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### delta_of_delta_encoder_core.f
rtl/core/dod_pkg.sv
rtl/core/dod_front.sv
rtl/core/dod_queue.sv
rtl/core/dod_back.sv
rtl/core/delta_of_delta_encoder_core.sv
sim/tb_delta_of_delta_encoder_core.sv
